FILE: rtl/core/harris_corner_response_unit_defines.svh
// Assertion macros shared by the harris corner response RTL
`ifndef HARRIS_CORNER_RESPONSE_UNIT_DEFINES_SVH
`define HARRIS_CORNER_RESPONSE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define HCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hcr check failed");
// Check a property on every clock edge, reset included
`define HCR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hcr check failed");
`else
`define HCR_ASSERT(lbl, clk, rst_n, prop)
`define HCR_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/hcr_pkg.sv
// Shared constants, types and state encodings of the harris corner response unit
`timescale 1ns / 1ps
`default_nettype none
package hcr_pkg;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DIM_MIN       = 4;
    localparam int LINES         = 5;
    localparam int SLOT_W        = 3;
    localparam int PATCH         = 5;
    localparam int WIN           = 3;
    localparam int EDGE_LAG      = 3;
    localparam int PIX_W         = 8;
    localparam int DIM_W         = 13;
    localparam int K_W           = 16;
    localparam int POS_W         = 12;
    localparam int RESP_W        = 47;
    localparam int SUM_W         = 24;
    localparam int XY_W          = 25;
    localparam int GRAD_W        = 11;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [K_W-1:0]   K_RESET      = 16'd2621;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_K      = 2'd2;

    typedef logic [PATCH-1:0][PATCH-1:0][PIX_W-1:0] patch_t;

    typedef struct packed {
        logic [SUM_W-1:0] sxx;
        logic [SUM_W-1:0] syy;
        logic [XY_W-1:0]  sxy;
    } sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LOAD_WAIT,
        ST_GRAD,
        ST_SCORE,
        ST_OUT
    } hcr_state_t;

    typedef enum logic [1:0] {
        GA_IDLE,
        GA_RUN,
        GA_DRAIN
    } grad_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_DET,
        SC_XY,
        SC_TSQ,
        SC_PHI,
        SC_PLO,
        SC_SUM,
        SC_CLAMP
    } score_state_t;
endpackage
`default_nettype wire

FILE: rtl/core/hcr_line_mem.sv
// Five-row pixel line store, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module hcr_line_mem #(
    parameter int DEPTH = hcr_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [hcr_pkg::SLOT_W-1:0]      wr_slot,
    input  logic [$clog2(DEPTH)-1:0]        wr_col,
    input  logic [hcr_pkg::PIX_W-1:0]       wr_data,
    input  logic                            rd_en,
    input  logic [hcr_pkg::SLOT_W-1:0]      rd_slot,
    input  logic [$clog2(DEPTH)-1:0]        rd_col,
    output logic [hcr_pkg::PIX_W-1:0]       rd_data
);
    logic [hcr_pkg::PIX_W-1:0] mem [hcr_pkg::LINES][DEPTH];
    logic [hcr_pkg::PIX_W-1:0] rd_data_reg;

    // Write the incoming pixel, read one patch pixel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot][wr_col] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_slot][rd_col];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

FILE: rtl/core/hcr_grad_acc.sv
// Sobel gradients over a 5x5 patch and window sums of their products
`timescale 1ns / 1ps
`default_nettype none
module hcr_grad_acc (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  hcr_pkg::patch_t patch,
    output logic            done,
    output hcr_pkg::sums_t  sums
);
    localparam logic [1:0] G_LAST = 2'(hcr_pkg::WIN - 1);

    hcr_pkg::grad_state_t state_reg, state_next;
    logic [1:0] gr_reg, gc_reg;
    logic       g_v_reg, p_v_reg;
    logic signed [hcr_pkg::GRAD_W-1:0]   gx_reg, gy_reg;
    logic signed [2*hcr_pkg::GRAD_W-1:0] pxx_reg, pyy_reg, pxy_reg;
    logic [hcr_pkg::SUM_W-1:0]           sxx_reg, syy_reg;
    logic signed [hcr_pkg::XY_W-1:0]     sxy_reg;
    logic signed [hcr_pkg::GRAD_W-1:0]   gx, gy;
    logic [hcr_pkg::PIX_W-1:0]           t [hcr_pkg::WIN][hcr_pkg::WIN];
    logic [hcr_pkg::GRAD_W-2:0]          px, nx, py, ny;

    // Gradient at the current window position
    always_comb
    begin
        for (int a = 0; a < hcr_pkg::WIN; a++)
        begin
            for (int b = 0; b < hcr_pkg::WIN; b++)
            begin
                t[a][b] = patch[3'(gr_reg) + 3'(a)][3'(gc_reg) + 3'(b)];
            end
        end
        px = 10'(t[0][2]) + (10'(t[1][2]) << 1) + 10'(t[2][2]);
        nx = 10'(t[0][0]) + (10'(t[1][0]) << 1) + 10'(t[2][0]);
        py = 10'(t[2][0]) + (10'(t[2][1]) << 1) + 10'(t[2][2]);
        ny = 10'(t[0][0]) + (10'(t[0][1]) << 1) + 10'(t[0][2]);
        gx = $signed({1'b0, px}) - $signed({1'b0, nx});
        gy = $signed({1'b0, py}) - $signed({1'b0, ny});
    end

    // Sequence the nine window positions and drain the pipeline
    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            hcr_pkg::GA_IDLE:
            begin
                if (start)
                begin
                    state_next = hcr_pkg::GA_RUN;
                end
            end
            hcr_pkg::GA_RUN:
            begin
                if (gr_reg == G_LAST && gc_reg == G_LAST)
                begin
                    state_next = hcr_pkg::GA_DRAIN;
                end
            end
            hcr_pkg::GA_DRAIN:
            begin
                if (!g_v_reg && !p_v_reg)
                begin
                    done       = 1'b1;
                    state_next = hcr_pkg::GA_IDLE;
                end
            end
            default:
            begin
                state_next = hcr_pkg::GA_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcr_pkg::GA_IDLE;
            gr_reg    <= '0;
            gc_reg    <= '0;
            g_v_reg   <= 1'b0;
            p_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            g_v_reg   <= (state_reg == hcr_pkg::GA_RUN);
            p_v_reg   <= g_v_reg;
            if (state_reg == hcr_pkg::GA_RUN)
            begin
                if (gc_reg == G_LAST)
                begin
                    gc_reg <= '0;
                    gr_reg <= gr_reg + 2'd1;
                end
                else
                begin
                    gc_reg <= gc_reg + 2'd1;
                end
            end
            else
            begin
                gr_reg <= '0;
                gc_reg <= '0;
            end
        end
    end

    // Gradient, product and accumulate stages
    always_ff @(posedge clk)
    begin
        gx_reg  <= gx;
        gy_reg  <= gy;
        pxx_reg <= gx_reg * gx_reg;
        pyy_reg <= gy_reg * gy_reg;
        pxy_reg <= gx_reg * gy_reg;
        if (start)
        begin
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else if (p_v_reg)
        begin
            sxx_reg <= sxx_reg + hcr_pkg::SUM_W'(pxx_reg);
            syy_reg <= syy_reg + hcr_pkg::SUM_W'(pyy_reg);
            sxy_reg <= sxy_reg + hcr_pkg::XY_W'(pxy_reg);
        end
    end

    assign sums.sxx = sxx_reg;
    assign sums.syy = syy_reg;
    assign sums.sxy = sxy_reg;
endmodule
`default_nettype wire

FILE: rtl/core/hcr_score.sv
// Harris score det - k*trace^2 in one-multiply steps, clamped at zero
`timescale 1ns / 1ps
`default_nettype none
module hcr_score (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  hcr_pkg::sums_t               sums,
    input  logic [hcr_pkg::K_W-1:0]      k,
    output logic                         done,
    output logic [hcr_pkg::RESP_W-1:0]   response
);
    localparam logic [32:0] HALF_LSB = 33'd32768;

    hcr_pkg::score_state_t state_reg, state_next;
    logic                done_reg;
    logic [47:0]         ssq_reg, xy2_reg;
    logic [hcr_pkg::XY_W-1:0] tr_reg;
    logic [49:0]         t2_reg, pen_hi_reg;
    logic [31:0]         pen_lo_reg;
    logic signed [48:0]  det_reg;
    logic [50:0]         pen_reg;
    logic [hcr_pkg::RESP_W-1:0] response_reg;

    logic [47:0]         ssq_prod;
    logic signed [49:0]  xy_prod;
    logic [49:0]         tsq_prod, phi_prod;
    logic [31:0]         plo_prod;
    logic [32:0]         plo_round;
    logic signed [51:0]  diff;

    assign ssq_prod  = sums.sxx * sums.syy;
    assign xy_prod   = $signed(sums.sxy) * $signed(sums.sxy);
    assign tsq_prod  = tr_reg * tr_reg;
    assign phi_prod  = k * t2_reg[49:16];
    assign plo_prod  = k * t2_reg[15:0];
    assign plo_round = 33'(pen_lo_reg) + HALF_LSB;
    assign diff      = 52'(det_reg) - $signed({1'b0, pen_reg});

    // Step through the arithmetic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcr_pkg::SC_IDLE:  if (start) state_next = hcr_pkg::SC_DET;
            hcr_pkg::SC_DET:   state_next = hcr_pkg::SC_XY;
            hcr_pkg::SC_XY:    state_next = hcr_pkg::SC_TSQ;
            hcr_pkg::SC_TSQ:   state_next = hcr_pkg::SC_PHI;
            hcr_pkg::SC_PHI:   state_next = hcr_pkg::SC_PLO;
            hcr_pkg::SC_PLO:   state_next = hcr_pkg::SC_SUM;
            hcr_pkg::SC_SUM:   state_next = hcr_pkg::SC_CLAMP;
            hcr_pkg::SC_CLAMP: state_next = hcr_pkg::SC_IDLE;
            default:           state_next = hcr_pkg::SC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcr_pkg::SC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == hcr_pkg::SC_CLAMP);
        end
    end

    // Datapath registers, at most one multiply per step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hcr_pkg::SC_DET:
            begin
                ssq_reg <= ssq_prod;
                tr_reg  <= hcr_pkg::XY_W'(sums.sxx) + hcr_pkg::XY_W'(sums.syy);
            end
            hcr_pkg::SC_XY:  xy2_reg    <= xy_prod[47:0];
            hcr_pkg::SC_TSQ: t2_reg     <= tsq_prod;
            hcr_pkg::SC_PHI: pen_hi_reg <= phi_prod;
            hcr_pkg::SC_PLO: pen_lo_reg <= plo_prod;
            hcr_pkg::SC_SUM:
            begin
                det_reg <= $signed({1'b0, ssq_reg}) - $signed({1'b0, xy2_reg});
                pen_reg <= 51'(pen_hi_reg) + 51'(plo_round[32:16]);
            end
            hcr_pkg::SC_CLAMP:
            begin
                response_reg <= (diff > 52'sd0) ? diff[hcr_pkg::RESP_W-1:0] : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign done     = done_reg;
    assign response = response_reg;
endmodule
`default_nettype wire

FILE: rtl/core/harris_corner_response_unit.sv
// Top level of the harris corner response unit: control, configuration, patch, output
// A pixel that completes no position leaves the control idle. Each result needs 25
// line store reads for the 5x5 patch, 9 gradient steps plus pipeline drain, and 7
// score steps of at most one multiply each. A pixel gives 0 to 4 results.
// Reset clears counters, control, configuration; line store and data start undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "harris_corner_response_unit_defines.svh"
module harris_corner_response_unit #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcr_pkg::ADDR_W-1:0]     paddr,
    input  logic [hcr_pkg::DATA_W-1:0]     pwdata,
    output logic [hcr_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic [hcr_pkg::PIX_W-1:0]      pixel,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    output logic [hcr_pkg::RESP_W-1:0]     response,
    output logic [hcr_pkg::POS_W-1:0]      out_row,
    output logic [hcr_pkg::POS_W-1:0]      out_col,
    output logic                           last_of_run,
    output logic                           result_valid,
    input  logic                           result_ready
);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = WW + 1;
    localparam int CSW    = CW + 2;
    localparam int RSW    = hcr_pkg::POS_W + 2;
    localparam int DW     = hcr_pkg::DIM_W;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] W_MIN = WW'(hcr_pkg::DIM_MIN);
    localparam logic [DW-1:0] H_MAX = DW'(hcr_pkg::MAX_HEIGHT);
    localparam logic [DW-1:0] H_MIN = DW'(hcr_pkg::DIM_MIN);
    localparam logic [2:0] P_LAST = 3'(hcr_pkg::PATCH - 1);
    localparam logic [hcr_pkg::SLOT_W-1:0] S_LAST = hcr_pkg::SLOT_W'(hcr_pkg::LINES - 1);

    function automatic logic [hcr_pkg::SLOT_W-1:0] slot_next(
        input logic [hcr_pkg::SLOT_W-1:0] s
    );
        return (s == S_LAST) ? '0 : s + 3'd1;
    endfunction

    function automatic logic [hcr_pkg::SLOT_W-1:0] slot_back(
        input logic [hcr_pkg::SLOT_W-1:0] s,
        input logic [hcr_pkg::SLOT_W-1:0] d
    );
        return (s >= d) ? s - d : 3'(hcr_pkg::LINES) - d + s;
    endfunction

    // Configuration registers
    logic [DW-1:0]          width_reg, height_reg;
    logic [hcr_pkg::K_W-1:0] k_reg;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hcr_pkg::WIDTH_RESET;
            height_reg <= hcr_pkg::HEIGHT_RESET;
            k_reg      <= hcr_pkg::K_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                hcr_pkg::REG_WIDTH:  width_reg  <= pwdata[DW-1:0];
                hcr_pkg::REG_HEIGHT: height_reg <= pwdata[DW-1:0];
                hcr_pkg::REG_K:      k_reg      <= pwdata[hcr_pkg::K_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[3:2])
            hcr_pkg::REG_WIDTH:  prdata = hcr_pkg::DATA_W'(width_reg);
            hcr_pkg::REG_HEIGHT: prdata = hcr_pkg::DATA_W'(height_reg);
            hcr_pkg::REG_K:      prdata = hcr_pkg::DATA_W'(k_reg);
            default:             prdata = '0;
        endcase
    end

    // Saturate the frame dimensions
    logic [WW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    always_comb
    begin
        if (width_reg < DW'(hcr_pkg::DIM_MIN))
            w_eff = W_MIN;
        else if ({1'b0, width_reg} > 14'(MAX_WIDTH))
            w_eff = W_MAX;
        else
            w_eff = WW'(width_reg);
        if (height_reg < H_MIN)
            h_eff = H_MIN;
        else if (height_reg > H_MAX)
            h_eff = H_MAX;
        else
            h_eff = height_reg;
    end

    // Raster position of the incoming pixel
    logic [CW-1:0]                 col_reg;
    logic [hcr_pkg::POS_W-1:0]     row_reg;
    logic [hcr_pkg::SLOT_W-1:0]    slot_reg;
    logic                          col_wrap, row_wrap, last_col, last_row, first_ok;
    logic [DW-1:0]                 r_pre;
    logic [hcr_pkg::POS_W-1:0]     r_cur;
    logic [CW-1:0]                 c_cur;
    logic [hcr_pkg::SLOT_W-1:0]    s_pre, s_cur;

    always_comb
    begin
        col_wrap = CMP_W'(col_reg) >= CMP_W'(w_eff);
        c_cur    = col_wrap ? '0 : col_reg;
        r_pre    = col_wrap ? DW'(row_reg) + DW'(1) : DW'(row_reg);
        s_pre    = col_wrap ? slot_next(slot_reg) : slot_reg;
        row_wrap = r_pre >= h_eff;
        r_cur    = row_wrap ? '0 : r_pre[hcr_pkg::POS_W-1:0];
        s_cur    = row_wrap ? '0 : s_pre;
        last_col = (CMP_W'(c_cur) + CMP_W'(1)) == CMP_W'(w_eff);
        last_row = (DW'(r_cur) + DW'(1)) == h_eff;
        first_ok = (r_cur >= hcr_pkg::POS_W'(hcr_pkg::EDGE_LAG)) &&
                   (CMP_W'(c_cur) >= CMP_W'(hcr_pkg::EDGE_LAG));
    end

    // Control
    hcr_pkg::hcr_state_t state_reg, state_next;
    logic [2:0]  ld_row_reg, ld_col_reg, rd_row_reg, rd_col_reg;
    logic        rd_v_reg;
    logic        pix_xfer, out_load, more, ld_last;
    logic        grad_done, score_done;
    logic [hcr_pkg::POS_W-1:0]  job_r_reg;
    logic [CW-1:0]              job_c_reg;
    logic [hcr_pkg::SLOT_W-1:0] job_slot_reg;
    logic        job_rv1_reg, job_cv1_reg, sel_i_reg, sel_j_reg;
    logic        result_valid_reg;

    assign pixel_ready = (state_reg == hcr_pkg::ST_IDLE);
    assign pix_xfer    = pixel_valid && pixel_ready;
    assign ld_last     = (ld_row_reg == P_LAST) && (ld_col_reg == P_LAST);
    assign more        = (!sel_j_reg && job_cv1_reg) || (!sel_i_reg && job_rv1_reg);

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            hcr_pkg::ST_IDLE:
            begin
                if (pix_xfer && first_ok)
                    state_next = hcr_pkg::ST_LOAD;
            end
            hcr_pkg::ST_LOAD:
            begin
                if (ld_last)
                    state_next = hcr_pkg::ST_LOAD_WAIT;
            end
            hcr_pkg::ST_LOAD_WAIT:
            begin
                state_next = hcr_pkg::ST_GRAD;
            end
            hcr_pkg::ST_GRAD:
            begin
                if (grad_done)
                    state_next = hcr_pkg::ST_SCORE;
            end
            hcr_pkg::ST_SCORE:
            begin
                if (score_done)
                    state_next = hcr_pkg::ST_OUT;
            end
            hcr_pkg::ST_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = more ? hcr_pkg::ST_LOAD : hcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcr_pkg::ST_IDLE;
            end
        endcase
    end

    // Position of the result being worked and its patch read address
    logic signed [RSW-1:0]      k_pos, x_raw;
    logic signed [CSW-1:0]      l_pos, y_raw;
    logic [hcr_pkg::POS_W-1:0]  x_row, d_row;
    logic [hcr_pkg::SLOT_W-1:0] rd_slot;
    logic [CW-1:0]              rd_col;

    always_comb
    begin
        k_pos = $signed(RSW'(job_r_reg)) - $signed(RSW'(hcr_pkg::EDGE_LAG))
              + $signed(RSW'(sel_i_reg));
        x_raw = k_pos - $signed(RSW'(1)) + $signed(RSW'(ld_row_reg));
        if (x_raw < 0)
            x_row = '0;
        else if (x_raw > $signed(RSW'(h_eff)) - $signed(RSW'(1)))
            x_row = hcr_pkg::POS_W'(h_eff - DW'(1));
        else
            x_row = x_raw[hcr_pkg::POS_W-1:0];
        d_row   = job_r_reg - x_row;
        rd_slot = slot_back(job_slot_reg, d_row[hcr_pkg::SLOT_W-1:0]);

        l_pos = $signed(CSW'(job_c_reg)) - $signed(CSW'(hcr_pkg::EDGE_LAG))
              + $signed(CSW'(sel_j_reg));
        y_raw = l_pos - $signed(CSW'(1)) + $signed(CSW'(ld_col_reg));
        if (y_raw < 0)
            rd_col = '0;
        else if (y_raw > $signed(CSW'(w_eff)) - $signed(CSW'(1)))
            rd_col = CW'(w_eff - WW'(1));
        else
            rd_col = y_raw[CW-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hcr_pkg::ST_IDLE;
            col_reg          <= '0;
            row_reg          <= '0;
            slot_reg         <= '0;
            ld_row_reg       <= '0;
            ld_col_reg       <= '0;
            rd_v_reg         <= 1'b0;
            sel_i_reg        <= 1'b0;
            sel_j_reg        <= 1'b0;
            job_rv1_reg      <= 1'b0;
            job_cv1_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == hcr_pkg::ST_LOAD);

            // Advance the raster position on each pixel transfer
            if (pix_xfer)
            begin
                job_rv1_reg <= last_row;
                job_cv1_reg <= last_col;
                sel_i_reg   <= 1'b0;
                sel_j_reg   <= 1'b0;
                if (last_col)
                begin
                    col_reg  <= '0;
                    row_reg  <= last_row ? '0 : r_cur + hcr_pkg::POS_W'(1);
                    slot_reg <= last_row ? '0 : slot_next(s_cur);
                end
                else
                begin
                    col_reg  <= c_cur + CW'(1);
                    row_reg  <= r_cur;
                    slot_reg <= s_cur;
                end
            end
            else if (out_load && more)
            begin
                if (!sel_j_reg && job_cv1_reg)
                begin
                    sel_j_reg <= 1'b1;
                end
                else
                begin
                    sel_i_reg <= 1'b1;
                    sel_j_reg <= 1'b0;
                end
            end

            // Walk the 5x5 patch
            if (state_reg == hcr_pkg::ST_LOAD)
            begin
                if (ld_col_reg == P_LAST)
                begin
                    ld_col_reg <= '0;
                    ld_row_reg <= ld_row_reg + 3'd1;
                end
                else
                begin
                    ld_col_reg <= ld_col_reg + 3'd1;
                end
            end
            else
            begin
                ld_row_reg <= '0;
                ld_col_reg <= '0;
            end

            // Hold the result until its transfer
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Job snapshot and patch capture
    hcr_pkg::patch_t patch_reg;
    logic [hcr_pkg::PIX_W-1:0] rd_data;

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            job_r_reg    <= r_cur;
            job_c_reg    <= c_cur;
            job_slot_reg <= s_cur;
        end
        rd_row_reg <= ld_row_reg;
        rd_col_reg <= ld_col_reg;
        if (rd_v_reg)
            patch_reg[rd_row_reg][rd_col_reg] <= rd_data;
    end

    hcr_line_mem #(
        .DEPTH(MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (pix_xfer),
        .wr_slot (s_cur),
        .wr_col  (c_cur),
        .wr_data (pixel),
        .rd_en   (state_reg == hcr_pkg::ST_LOAD),
        .rd_slot (rd_slot),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

    hcr_pkg::sums_t sums;
    logic [hcr_pkg::RESP_W-1:0] score_resp;

    hcr_grad_acc u_grad_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == hcr_pkg::ST_LOAD_WAIT),
        .patch (patch_reg),
        .done  (grad_done),
        .sums  (sums)
    );

    hcr_score u_score (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (grad_done),
        .sums     (sums),
        .k        (k_reg),
        .done     (score_done),
        .response (score_resp)
    );

    // Output register
    logic [hcr_pkg::RESP_W-1:0] response_reg;
    logic [hcr_pkg::POS_W-1:0]  out_row_reg, out_col_reg;
    logic                       last_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            response_reg <= score_resp;
            out_row_reg  <= k_pos[hcr_pkg::POS_W-1:0];
            out_col_reg  <= hcr_pkg::POS_W'(l_pos);
            last_reg     <= !more;
        end
    end

    assign response     = response_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign last_of_run  = last_reg;
    assign result_valid = result_valid_reg;

    `HCR_ASSERT(a_grad_done_in_grad, clk, rst_n, grad_done |-> state_reg == hcr_pkg::ST_GRAD)
    `HCR_ASSERT(a_score_done_in_score, clk, rst_n, score_done |-> state_reg == hcr_pkg::ST_SCORE)
    `HCR_ASSERT(a_job_starts_load, clk, rst_n, (pix_xfer && first_ok) |=> state_reg == hcr_pkg::ST_LOAD)
    `HCR_ASSERT_RST(a_one_unit_done, clk, !(grad_done && score_done))
endmodule
`default_nettype wire

FILE: verif/harris_corner_response_unit_test.sv
// Self-checking testbench for the harris corner response unit
`timescale 1ns / 1ps
module harris_corner_response_unit_test;
    localparam int STORE_W = 4096;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // Cycles a pixel may still spend in the block after the last result left
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [hcr_pkg::RESP_W-1:0] response;
        logic [hcr_pkg::POS_W-1:0]  row;
        logic [hcr_pkg::POS_W-1:0]  col;
        logic                       last;
    } corner_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [hcr_pkg::ADDR_W-1:0]   paddr;
    logic [hcr_pkg::DATA_W-1:0]   pwdata;
    logic [hcr_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic [hcr_pkg::PIX_W-1:0]    pixel;
    logic                         pixel_valid;
    logic                         pixel_ready;
    logic [hcr_pkg::RESP_W-1:0]   response;
    logic [hcr_pkg::POS_W-1:0]    out_row;
    logic [hcr_pkg::POS_W-1:0]    out_col;
    logic                         last_of_run;
    logic                         result_valid;
    logic                         result_ready;

    // Shadow copy of the block state
    logic [hcr_pkg::PIX_W-1:0] line_rows [hcr_pkg::LINES][STORE_W];
    logic [hcr_pkg::DIM_W-1:0] cfg_width;
    logic [hcr_pkg::DIM_W-1:0] cfg_height;
    logic [hcr_pkg::K_W-1:0]   cfg_k;
    int               cur_row;
    int               cur_col;

    corner_t pending_corners[$];
    int      mismatches;
    bit      failed;
    int      tx_idle_pct;
    int      rx_idle_pct;
    bit      hold_req;
    int      hold_count;
    int      items_sent;

    harris_corner_response_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel        (pixel),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .response     (response),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit
    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < hcr_pkg::DIM_MIN) w = hcr_pkg::DIM_MIN;
        if (w > hcr_pkg::MAX_WIDTH_DEF) w = hcr_pkg::MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cfg_height;
        if (h < hcr_pkg::DIM_MIN) h = hcr_pkg::DIM_MIN;
        if (h > hcr_pkg::MAX_HEIGHT) h = hcr_pkg::MAX_HEIGHT;
        return h;
    endfunction

    // Edge-replicated pixel fetch
    function automatic int border_pixel(int r, int c, int w, int h);
        if (r < 0) r = 0;
        if (r > h - 1) r = h - 1;
        if (c < 0) c = 0;
        if (c > w - 1) c = w - 1;
        return int'(line_rows[r % hcr_pkg::LINES][c]);
    endfunction

    // Harris response of interior position (k,l)
    function automatic logic [hcr_pkg::RESP_W-1:0] corner_score(int k, int l, int w, int h);
        longint sxx;
        longint syy;
        longint sxy;
        longint det;
        longint unsigned tr;
        longint unsigned t2;
        longint unsigned pen;
        longint diff;
        int gx;
        int gy;
        int p;
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                gx = 0;
                gy = 0;
                for (int a = 0; a < 3; a++)
                begin
                    for (int b = 0; b < 3; b++)
                    begin
                        p = border_pixel(k + dr + a, l + dc + b, w, h);
                        // Sobel taps: x weights by column, y weights by row
                        gx += p * (b - 1) * ((a == 1) ? 2 : 1);
                        gy += p * (a - 1) * ((b == 1) ? 2 : 1);
                    end
                end
                sxx += longint'(gx) * gx;
                syy += longint'(gy) * gy;
                sxy += longint'(gx) * gy;
            end
        end
        det = sxx * syy - sxy * sxy;
        tr = longint'(sxx + syy);
        t2 = tr * tr;
        pen = longint'(cfg_k) * (t2 >> 16)
            + ((longint'(cfg_k) * (t2 & 64'hFFFF) + 64'd32768) >> 16);
        diff = det - longint'(pen);
        if (diff <= 0) return '0;
        return diff[hcr_pkg::RESP_W-1:0];
    endfunction

    // Advance the shadow state by one accepted pixel and queue its results
    task automatic predict_corners(input logic [hcr_pkg::PIX_W-1:0] value);
        int w;
        int h;
        int rows[$];
        int cols[$];
        corner_t item;
        w = eff_width();
        h = eff_height();
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        line_rows[cur_row % hcr_pkg::LINES][cur_col] = value;
        if (cur_row >= 3) rows.push_back(cur_row - 3);
        if (cur_row == h - 1) rows.push_back(cur_row - 2);
        if (cur_col >= 3) cols.push_back(cur_col - 3);
        if (cur_col == w - 1) cols.push_back(cur_col - 2);
        foreach (rows[i])
        begin
            foreach (cols[j])
            begin
                item.response = corner_score(rows[i], cols[j], w, h);
                item.row = rows[i][hcr_pkg::POS_W-1:0];
                item.col = cols[j][hcr_pkg::POS_W-1:0];
                item.last = (i == rows.size() - 1) && (j == cols.size() - 1);
                pending_corners.push_back(item);
            end
        end
        cur_col++;
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endtask

    // Offer one pixel, with a random gap before it
    task automatic send_pixel(input logic [hcr_pkg::PIX_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 8) gap++;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= value;
        @(posedge clk);
        while (!pixel_ready) @(posedge clk);
        predict_corners(value);
        items_sent++;
    endtask

    task automatic stop_pixels();
        pixel_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain_results();
        while (pending_corners.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [hcr_pkg::DATA_W-1:0] data,
                              output logic [hcr_pkg::DATA_W-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        failed = 1'b1;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d", what, want, got);
    endtask

    // Write a register, mirror it, then read it back unless it is the unused index
    task automatic write_reg(input logic [1:0] idx, input logic [hcr_pkg::DATA_W-1:0] data);
        logic [hcr_pkg::DATA_W-1:0] rd;
        logic [hcr_pkg::DATA_W-1:0] want;
        apb_access(1'b1, idx, data, rd);
        case (idx)
            hcr_pkg::REG_WIDTH:  cfg_width = data[hcr_pkg::DIM_W-1:0];
            hcr_pkg::REG_HEIGHT: cfg_height = data[hcr_pkg::DIM_W-1:0];
            hcr_pkg::REG_K:      cfg_k = data[hcr_pkg::K_W-1:0];
            default:    ;
        endcase
        if (idx != REG_UNUSED)
        begin
            apb_access(1'b0, idx, '0, rd);
            want = (idx == hcr_pkg::REG_WIDTH) ? hcr_pkg::DATA_W'(cfg_width)
                 : (idx == hcr_pkg::REG_HEIGHT) ? hcr_pkg::DATA_W'(cfg_height)
                 : hcr_pkg::DATA_W'(cfg_k);
            if (rd !== want) report_mismatch("register", want, rd);
        end
    endtask

    // Send one whole frame of the current size
    // style 0 random, 1 flat, 2 extremes checker, 3 vertical edge, 4 sparse spots
    task automatic send_frame(input int style);
        int w;
        int h;
        logic [hcr_pkg::PIX_W-1:0] v;
        logic [hcr_pkg::PIX_W-1:0] base;
        w = eff_width();
        h = eff_height();
        base = $urandom_range(255);
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                case (style)
                    1: v = base;
                    2: v = ((r + c) % 2) ? 8'hFF : 8'h00;
                    3: v = (c < w / 2) ? base : ~base;
                    4: v = ($urandom_range(3) == 0) ? 8'hFF : base;
                    default: v = $urandom_range(255);
                endcase
                send_pixel(v);
            end
        end
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        corner_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_corners.size() == 0)
            begin
                report_mismatch("unexpected result row", 0, out_row);
            end
            else
            begin
                want = pending_corners.pop_front();
                if (response !== want.response)
                    report_mismatch("response", want.response, response);
                if (out_row !== want.row) report_mismatch("out_row", want.row, out_row);
                if (out_col !== want.col) report_mismatch("out_col", want.col, out_col);
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", want.last, last_of_run);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && hold_count == 0)
        begin
            hold_count <= 600;
            hold_req <= 1'b0;
            result_ready <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic test_register_reset();
        logic [hcr_pkg::DATA_W-1:0] rd;
        apb_access(1'b0, hcr_pkg::REG_WIDTH, '0, rd);
        if (rd !== hcr_pkg::DATA_W'(hcr_pkg::WIDTH_RESET))
            report_mismatch("width reset", hcr_pkg::WIDTH_RESET, rd);
        apb_access(1'b0, hcr_pkg::REG_HEIGHT, '0, rd);
        if (rd !== hcr_pkg::DATA_W'(hcr_pkg::HEIGHT_RESET))
            report_mismatch("height reset", hcr_pkg::HEIGHT_RESET, rd);
        apb_access(1'b0, hcr_pkg::REG_K, '0, rd);
        if (rd !== hcr_pkg::DATA_W'(hcr_pkg::K_RESET))
            report_mismatch("k reset", hcr_pkg::K_RESET, rd);
    endtask

    // Largest register values, read back only: a full frame at that size is too long
    task automatic test_register_extremes();
        write_reg(hcr_pkg::REG_WIDTH, 32'h1FFF);
        write_reg(hcr_pkg::REG_HEIGHT, 32'h1FFF);
        write_reg(hcr_pkg::REG_K, 32'hFFFF);
        write_reg(REG_UNUSED, 32'h5);
    endtask

    // Undersized dimensions clamp to 4x4; extreme pixels with zero k
    task automatic test_clamped_extremes();
        write_reg(hcr_pkg::REG_WIDTH, 32'd1);
        write_reg(hcr_pkg::REG_HEIGHT, 32'd0);
        write_reg(hcr_pkg::REG_K, 32'd0);
        send_frame(2);
        stop_pixels();
        drain_results();
    endtask

    // Hold the result side off while pixels keep coming
    task automatic test_backpressure();
        write_reg(hcr_pkg::REG_WIDTH, 32'd7);
        write_reg(hcr_pkg::REG_HEIGHT, 32'd5);
        write_reg(hcr_pkg::REG_K, 32'hFFFF);
        hold_req <= 1'b1;
        send_frame(0);
        stop_pixels();
        drain_results();
    endtask

    task automatic test_random_frames(input int target);
        int style;
        while (items_sent < target)
        begin
            write_reg(hcr_pkg::REG_WIDTH, $urandom_range(9, 4));
            write_reg(hcr_pkg::REG_HEIGHT, $urandom_range(6, 4));
            case ($urandom_range(3))
                0: write_reg(hcr_pkg::REG_K, 32'd0);
                1: write_reg(hcr_pkg::REG_K, 32'hFFFF);
                default: write_reg(hcr_pkg::REG_K, $urandom_range(6000));
            endcase
            style = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
            send_frame(style);
            stop_pixels();
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pixel = '0;
        pixel_valid = 1'b0;
        result_ready = 1'b0;
        hold_req = 1'b0;
        hold_count = 0;
        mismatches = 0;
        failed = 1'b0;
        items_sent = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cfg_width = hcr_pkg::WIDTH_RESET;
        cfg_height = hcr_pkg::HEIGHT_RESET;
        cfg_k = hcr_pkg::K_RESET;
        cur_row = 0;
        cur_col = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_register_extremes();
        test_clamped_extremes();
        test_backpressure();
        tx_idle_pct = 35;
        rx_idle_pct = 69;
        test_random_frames(100);
        tx_idle_pct = 69;
        rx_idle_pct = 35;
        test_random_frames(180);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(250);

        drain_results();
        if (pending_corners.size() != 0) failed = 1'b1;
        if (!failed)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
